// ===== rtl/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg
// Shared constants for the sorted priority list: default sizes, status codes and op codes.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int TAG_BITS_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Round a bit count up to whole bytes.
  function automatic int byte_pad(input int bits);
    byte_pad = ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ===== rtl/sorted_priority_list.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_list
// Table of up to DEPTH (key, tag) entries held in descending key order.
// ----------------------------------------------------------------------------
// Entries live in one synchronous memory, kept sorted with the largest key at
// address 0. Every beat on the input (insert by key and tag, or remove by tag)
// yields one result beat with a status, the entry count after the operation
// and the head entry (zero when the table is empty). Each operation is one
// sweep over the occupied entries, a memory read per entry and a write-back
// wherever an entry moves or the new entry lands; an insert into a full
// table skips the sweep and reports full. A new entry goes behind all entries
// with a strictly larger key; a remove takes the first matching tag. A new
// input beat is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
module sorted_priority_list #(
  parameter int DEPTH    = spl_pkg::DEPTH_DEF,
  parameter int TAG_BITS = spl_pkg::TAG_BITS_DEF,
  parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // func, key, tag (from bit 0 up), zero padded to bytes
  input  logic [spl_pkg::byte_pad(1 + KEY_BITS + TAG_BITS)-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status, entry_count, head_valid, head_key, head_tag (from bit 0 up), padded
  output logic [spl_pkg::byte_pad(spl_pkg::STATUS_W + $clog2(DEPTH + 1) + 1
                                  + KEY_BITS + TAG_BITS)-1:0] m_tdata
);
  import spl_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = KEY_BITS + TAG_BITS;
  localparam int IN_W  = 1 + KEY_BITS + TAG_BITS;
  localparam int OUT_W = STATUS_W + CW + 1 + KEY_BITS + TAG_BITS;
  localparam int OUT_PW = byte_pad(OUT_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state, state_next;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic          re;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic                op, op_next;
  logic [KEY_BITS-1:0] nkey, nkey_next;
  logic [TAG_BITS-1:0] ntag, ntag_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic                hit, hit_next;
  logic [EW-1:0]       carry, carry_next;
  logic [STATUS_W-1:0] status, status_next;
  logic [KEY_BITS-1:0] head_key;
  logic [TAG_BITS-1:0] head_tag;
  logic [OUT_W-1:0]    out_word;
  logic                out_valid, out_valid_next;
  logic                in_fire;

  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;

  assign rd_key  = rd_data[EW-1:TAG_BITS];
  assign rd_tag  = rd_data[TAG_BITS-1:0];
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_PW - OUT_W){1'b0}}, out_word};

  always_comb begin
    state_next     = state;
    op_next        = op;
    nkey_next      = nkey;
    ntag_next      = ntag;
    idx_next       = idx;
    cnt_next       = cnt;
    hit_next       = hit;
    carry_next     = carry;
    status_next    = status;
    out_valid_next = out_valid;
    re    = 1'b0;
    raddr = idx[AW-1:0];
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = {nkey, ntag};
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          op_next   = s_tdata[0];
          nkey_next = s_tdata[KEY_BITS:1];
          ntag_next = s_tdata[IN_W-1:KEY_BITS+1];
          idx_next  = '0;
          hit_next  = 1'b0;
          if (s_tdata[0] == OP_INSERT && cnt == CW'(DEPTH)) begin
            status_next = ST_FULL;
            state_next  = S_FIN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx == cnt) begin
          // end of the occupied range
          if (op == OP_INSERT) begin
            we          = 1'b1;
            wdata       = hit ? carry : {nkey, ntag};
            cnt_next    = cnt + CW'(1);
            status_next = ST_DONE;
          end else begin
            status_next = hit ? ST_DONE : ST_NOT_FOUND;
            if (hit) begin
              cnt_next = cnt - CW'(1);
            end
          end
          state_next = S_FIN;
        end else begin
          re         = 1'b1;
          state_next = S_WR;
        end
      end
      S_WR: begin
        if (op == OP_INSERT) begin
          if (hit) begin
            we         = 1'b1;
            wdata      = carry;
            carry_next = rd_data;
          end else if ($signed(rd_key) <= $signed(nkey)) begin
            we         = 1'b1;
            wdata      = {nkey, ntag};
            carry_next = rd_data;
            hit_next   = 1'b1;
          end
        end else begin
          if (hit) begin
            // close the gap: move this entry up one slot
            we    = 1'b1;
            waddr = AW'(idx - CW'(1));
            wdata = rd_data;
          end else if (rd_tag == ntag) begin
            hit_next = 1'b1;
          end
        end
        idx_next   = idx + CW'(1);
        state_next = S_RD;
      end
      S_FIN: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    nkey   <= nkey_next;
    ntag   <= ntag_next;
    idx    <= idx_next;
    hit    <= hit_next;
    carry  <= carry_next;
    status <= status_next;
    // shadow copy of entry 0
    if (we && waddr == '0) begin
      head_key <= wdata[EW-1:TAG_BITS];
      head_tag <= wdata[TAG_BITS-1:0];
    end
    if (state == S_FIN && (!out_valid || m_tready)) begin
      if (cnt != '0) begin
        out_word <= {head_tag, head_key, 1'b1, cnt, status};
      end else begin
        out_word <= {{(TAG_BITS + KEY_BITS + 1){1'b0}}, cnt, status};
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (cnt == $past(cnt)) || (cnt == $past(cnt) + CW'(1)) || (cnt + CW'(1) == $past(cnt)))
    else $error("entry count moved by more than one");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(waddr) <= cnt))
    else $error("memory write beyond occupied range");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && status == ST_FULL) |-> (cnt == CW'(DEPTH)))
    else $error("full status with free entries");

  a_sweep_idle_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_WR) |-> (idx <= cnt))
    else $error("sweep index past entry count");
`endif

endmodule

// ===== sim/sorted_priority_list_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_list_tb
// Self-checking bench for the sorted priority list.
// ----------------------------------------------------------------------------
// Inserts and removes are queued by the stimulus process and sent by a
// clocked driver. Each accepted beat updates a scoreboard copy of the sorted
// table, and the predicted status, count and head are queued. The monitor
// checks every result beat against the oldest prediction. Both sides idle in
// random bursts. The receiver holds off once for a long stretch, and the
// sender drains between phases. A directed pass covers the corner cases, and
// random traffic steers occupancy mostly low, with occasional fills to full.
// ----------------------------------------------------------------------------
module sorted_priority_list_tb;

  import spl_pkg::*;

  localparam int DEPTH    = DEPTH_DEF;
  localparam int KEY_BITS = KEY_BITS_DEF;
  localparam int TAG_BITS = TAG_BITS_DEF;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int S_W      = byte_pad(1 + KEY_BITS + TAG_BITS);
  localparam int M_W      = byte_pad(STATUS_W + CNT_W + 1 + KEY_BITS + TAG_BITS);
  localparam int HKEY_LO  = STATUS_W + CNT_W + 1;
  localparam int HTAG_LO  = HKEY_LO + KEY_BITS;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic                       func;
    logic signed [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0]        tag;
  } op_t;

  typedef struct {
    logic [STATUS_W-1:0]        status;
    logic [CNT_W-1:0]           count;
    logic                       head_valid;
    logic signed [KEY_BITS-1:0] head_key;
    logic [TAG_BITS-1:0]        head_tag;
  } res_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;

  sorted_priority_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scoreboard copy of the sorted table
  logic signed [KEY_BITS-1:0] list_keys [DEPTH];
  logic [TAG_BITS-1:0]        list_tags [DEPTH];
  int                         list_len = 0;

  res_t expected_results [$];
  op_t  pending_ops [$];
  int   total_ops = 0;
  int   got_cnt = 0;
  int   errors = 0;
  bit   quiet = 1'b0;

  // stimulus-side view of which tags are held, used to aim removes
  logic [TAG_BITS-1:0] held_tags [$];
  int seg_left = 0;
  int seg_target = 0;

  function automatic res_t list_apply(input op_t op);
    res_t r;
    int   pos;
    pos = 0;
    r.status = ST_DONE;
    if (op.func == OP_INSERT) begin
      if (list_len >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        while (pos < list_len && list_keys[pos] > op.key) pos++;
        for (int i = list_len; i > pos; i--) begin
          list_keys[i] = list_keys[i-1];
          list_tags[i] = list_tags[i-1];
        end
        list_keys[pos] = op.key;
        list_tags[pos] = op.tag;
        list_len++;
      end
    end else begin
      while (pos < list_len && list_tags[pos] != op.tag) pos++;
      if (pos >= list_len) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < list_len; i++) begin
          list_keys[i] = list_keys[i+1];
          list_tags[i] = list_tags[i+1];
        end
        list_len--;
      end
    end
    r.count      = CNT_W'(list_len);
    r.head_valid = (list_len > 0);
    r.head_key   = (list_len > 0) ? list_keys[0] : '0;
    r.head_tag   = (list_len > 0) ? list_tags[0] : '0;
    return r;
  endfunction

  task automatic add_op(input logic func, input logic [KEY_BITS-1:0] key,
                        input logic [TAG_BITS-1:0] tag);
    op_t op;
    int  idx;
    op.func = func;
    op.key  = key;
    op.tag  = tag;
    pending_ops.push_back(op);
    total_ops++;
    if (func == OP_INSERT) begin
      if (held_tags.size() < DEPTH) held_tags.push_back(tag);
    end else begin
      idx = -1;
      foreach (held_tags[i]) if (idx < 0 && held_tags[i] == tag) idx = i;
      if (idx >= 0) held_tags.delete(idx);
    end
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return KEY_BITS'($signed($urandom_range(6)) - 3);
    if (sel < 50) begin
      case ($urandom_range(3))
        0: return {1'b0, {(KEY_BITS-1){1'b1}}};
        1: return {1'b1, {(KEY_BITS-1){1'b0}}};
        2: return '1;
        default: return '0;
      endcase
    end
    return KEY_BITS'($urandom);
  endfunction

  function automatic logic [TAG_BITS-1:0] pick_tag();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return TAG_BITS'($urandom_range(7));
    if (sel < 60) return ($urandom_range(1) != 0) ? '1 : '0;
    return TAG_BITS'($urandom);
  endfunction

  // Random traffic in segments, each steering occupancy toward a target;
  // mostly small tables, now and then a fill past full.
  task automatic add_random(input int n);
    bit do_insert;
    for (int i = 0; i < n; i++) begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(60, 20);
        seg_target = ($urandom_range(9) == 0) ? DEPTH : $urandom_range(16);
      end
      seg_left--;
      if (held_tags.size() < seg_target) do_insert = ($urandom_range(99) < 75);
      else do_insert = ($urandom_range(99) < 25);
      if (do_insert) begin
        add_op(OP_INSERT, pick_key(), pick_tag());
      end else if (held_tags.size() != 0 && $urandom_range(99) < 80) begin
        add_op(OP_REMOVE, KEY_BITS'($urandom),
               held_tags[$urandom_range(held_tags.size() - 1)]);
      end else begin
        add_op(OP_REMOVE, KEY_BITS'($urandom), pick_tag());
      end
    end
  endtask

  // driver
  op_t tx_cur;
  int  tx_gap = 0;
  int  tx_idle_pct = 0;
  int  tx_loads = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(list_apply(tx_cur));
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          if (!quiet && $urandom_range(99) < tx_idle_pct) begin
            tx_gap = $urandom_range(9);
            s_tvalid <= 1'b0;
          end else begin
            tx_cur = pending_ops.pop_front();
            tx_loads++;
            if (tx_loads % 64 == 0) tx_idle_pct = $urandom_range(3) * 15;
            s_tvalid <= 1'b1;
            s_tdata  <= S_W'({tx_cur.tag, tx_cur.key, tx_cur.func});
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  int rx_hold = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!hold_done && got_cnt >= HOLD_AT) begin
      rx_hold   <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor
  int rx_gap = 0;
  int rx_idle_pct = 0;

  always @(posedge clk) begin
    res_t exp_r;
    res_t act;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        act.status     = m_tdata[0 +: STATUS_W];
        act.count      = m_tdata[STATUS_W +: CNT_W];
        act.head_valid = m_tdata[STATUS_W + CNT_W];
        act.head_key   = m_tdata[HKEY_LO +: KEY_BITS];
        act.head_tag   = m_tdata[HTAG_LO +: TAG_BITS];
        got_cnt <= got_cnt + 1;
        if ((got_cnt + 1) % 64 == 0) rx_idle_pct = $urandom_range(3) * 15;
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction pending");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (act.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, act.status);
            errors++;
          end
          if (act.count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, act.count);
            errors++;
          end
          if (act.head_valid !== exp_r.head_valid) begin
            $error("head_valid: expected %0d, got %0d", exp_r.head_valid, act.head_valid);
            errors++;
          end
          if (act.head_key !== exp_r.head_key) begin
            $error("head_key: expected %0d, got %0d", exp_r.head_key, act.head_key);
            errors++;
          end
          if (act.head_tag !== exp_r.head_tag) begin
            $error("head_tag: expected 0x%0h, got 0x%0h", exp_r.head_tag, act.head_tag);
            errors++;
          end
        end
      end
      if (rx_hold != 0) begin
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < rx_idle_pct) begin
        rx_gap = $urandom_range(9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table, extremes, equal keys, duplicate tags, drain to empty
    add_op(OP_REMOVE, '0, '0);
    add_op(OP_INSERT, {1'b0, {(KEY_BITS-1){1'b1}}}, '1);
    add_op(OP_INSERT, {1'b1, {(KEY_BITS-1){1'b0}}}, '0);
    add_op(OP_INSERT, '0, 16'd1);
    add_op(OP_INSERT, '0, 16'd2);
    add_op(OP_INSERT, '1, 16'd3);
    add_op(OP_INSERT, '0, 16'd1);
    add_op(OP_REMOVE, '1, 16'd1);
    add_op(OP_REMOVE, 32'h5a5a_a5a5, 16'h1234);
    add_op(OP_REMOVE, '0, '1);
    add_op(OP_INSERT, 32'h5555_5555, 16'haaaa);
    add_op(OP_INSERT, 32'haaaa_aaaa, 16'h5555);
    add_op(OP_REMOVE, '0, 16'haaaa);
    add_op(OP_REMOVE, '0, 16'h5555);
    add_op(OP_REMOVE, '0, 16'd1);
    add_op(OP_REMOVE, '0, 16'd2);
    add_op(OP_REMOVE, '0, 16'd3);
    add_op(OP_REMOVE, '1, '0);
    add_op(OP_REMOVE, '0, '0);
    wait (got_cnt == total_ops);

    add_random(700);
    wait (got_cnt == total_ops);
    add_random(650);
    wait (got_cnt == total_ops);

    quiet = 1'b1;
    add_random(175);
    wait (got_cnt == total_ops);
    repeat (150) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
